@@ src/flwq_pkg.sv @@
// Package for the fixed-length walk query block.
// Holds the sequencer state type, the cell control word and field widths.
// Depends on nothing; the cell and the top level import it.
package flwq_pkg;

    // Widths of the input fields.
    localparam int NODE_W = 3;
    localparam int LEN_W  = 8;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN
    } t_state;

    // Control word broadcast from the sequencer to every cell.
    typedef struct packed {
        logic wr_en;   // set one adjacency bit in the selected row
        logic load;    // start a frontier holding only the selected node
        logic step;    // replace the frontier bit by the next-step bit
        logic clear;   // empty the frontier
    } t_cell_ctl;

endpackage

@@ src/flwq_cell.sv @@
// One node cell: holds the node's outgoing adjacency row and its frontier bit.
// Passes the running union of frontier rows on to the next cell of the chain.
// Depends on flwq_pkg.
module flwq_cell #(
    parameter int NODE_COUNT = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  flwq_pkg::t_cell_ctl      i_ctl,
    input  logic                     i_sel,
    input  logic [flwq_pkg::NODE_W-1:0] i_col,
    input  logic                     i_next_bit,
    input  logic [NODE_COUNT-1:0]    i_acc,
    output logic [NODE_COUNT-1:0]    o_acc,
    output logic                     o_front
);
    import flwq_pkg::*;

    logic [NODE_COUNT-1:0] r_row;
    logic [NODE_COUNT-1:0] n_row;
    logic                  r_front;
    logic                  n_front;

    // Row update: set the addressed column when this row is selected.
    always_comb begin
        n_row = r_row;
        for (int c = 0; c < NODE_COUNT; c++) begin
            if (i_ctl.wr_en && i_sel && (int'(i_col) == c)) begin
                n_row[c] = 1'b1;
            end
        end
    end

    // Frontier bit update.
    always_comb begin
        n_front = r_front;
        if (i_ctl.clear) begin
            n_front = 1'b0;
        end else if (i_ctl.load) begin
            n_front = i_sel;
        end else if (i_ctl.step) begin
            n_front = i_next_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_front <= 1'b0;
        end else begin
            r_row   <= n_row;
            r_front <= n_front;
        end
    end

    // Add this row to the union when the node is in the frontier.
    assign o_acc   = i_acc | (r_front ? r_row : '0);
    assign o_front = r_front;

endmodule

@@ src/fixed_length_walk_query_top.sv @@
// Top level of the fixed-length walk query block.
// Holds the sequencer, the output register and the chain of node cells.
// Depends on flwq_pkg and flwq_cell.
//
//   channel | direction | handshake          | fields
//   --------+-----------+--------------------+-------------------------------------
//   input   | in        | i_valid / o_ready  | i_mode, i_node_a, i_node_b, i_walk_length
//   result  | out       | o_valid / i_ready  | o_walk_exists
//
// An add-edge word gives no result.
// A query loads its start node into the frontier, makes one walk step per cycle
// (walk_length steps, fewer when the frontier empties), then moves its answer into
// the output register; a query that answers at once (bad node, zero or too long a
// walk) goes straight to its final state. The cell chain forms each next frontier.
// Reset is synchronous and active low; it clears the graph and the frontier.
// A result waiting in the output register does not block the next input word; a
// finished query waits in its final state only while the output register is full.
module fixed_length_walk_query_top #(
    parameter int NODE_COUNT      = 8,
    parameter int MAX_WALK_LENGTH = 255
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_mode,
    input  logic [flwq_pkg::NODE_W-1:0]   i_node_a,
    input  logic [flwq_pkg::NODE_W-1:0]   i_node_b,
    input  logic [flwq_pkg::LEN_W-1:0]    i_walk_length,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_walk_exists
);
    import flwq_pkg::*;

    t_state                r_state;
    t_state                n_state;
    logic [LEN_W-1:0]      r_steps;
    logic [LEN_W-1:0]      n_steps;
    logic [NODE_W-1:0]     r_dst;
    logic [NODE_W-1:0]     n_dst;
    logic                  r_result;
    logic                  n_result;
    logic                  r_out_valid;
    logic                  r_out_data;
    t_cell_ctl             ctl;
    logic                  in_range;
    logic                  len_bad;
    logic                  out_load;
    logic                  dst_hit;
    logic [NODE_COUNT-1:0] next_vec;
    logic [NODE_COUNT-1:0] cell_sel;
    logic [NODE_COUNT-1:0] front_vec;
    logic [NODE_COUNT-1:0] acc [NODE_COUNT+1];

    // Checks on the incoming word.
    assign in_range = (int'(i_node_a) < NODE_COUNT) && (int'(i_node_b) < NODE_COUNT);
    assign len_bad  = (i_walk_length == '0) ||
                      (int'(i_walk_length) > MAX_WALK_LENGTH);

    // Chain of node cells; the union of frontier rows ripples down the chain.
    assign acc[0] = '0;
    for (genvar g = 0; g < NODE_COUNT; g++) begin : g_cell
        assign cell_sel[g] = (int'(i_node_a) == g);

        flwq_cell #(
            .NODE_COUNT (NODE_COUNT)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_sel      (cell_sel[g]),
            .i_col      (i_node_b),
            .i_next_bit (next_vec[g]),
            .i_acc      (acc[g]),
            .o_acc      (acc[g+1]),
            .o_front    (front_vec[g])
        );
    end
    assign next_vec = acc[NODE_COUNT];

    // Destination bit of the next frontier.
    always_comb begin
        dst_hit = 1'b0;
        for (int c = 0; c < NODE_COUNT; c++) begin
            if (int'(r_dst) == c) begin
                dst_hit = dst_hit | next_vec[c];
            end
        end
    end

    // A finished query moves to the output register when it is free.
    assign out_load = (r_state == ST_FIN) && (!r_out_valid || i_ready);
    assign o_ready  = (r_state == ST_IDLE);

    // Sequencer: next state and cell control.
    always_comb begin
        n_state  = r_state;
        n_steps  = r_steps;
        n_dst    = r_dst;
        n_result = r_result;
        ctl      = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (!i_mode) begin
                        ctl.wr_en = in_range;
                    end else if (!in_range || len_bad) begin
                        ctl.clear = 1'b1;
                        n_result  = 1'b0;
                        n_state   = ST_FIN;
                    end else begin
                        ctl.load = 1'b1;
                        n_steps  = i_walk_length;
                        n_dst    = i_node_b;
                        n_state  = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                ctl.step = 1'b1;
                n_steps  = r_steps - LEN_W'(1);
                if ((r_steps == LEN_W'(1)) || (front_vec == '0) || (next_vec == '0)) begin
                    n_result = dst_hit;
                    n_state  = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_steps  <= n_steps;
        r_dst    <= n_dst;
        r_result <= n_result;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= r_result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_walk_exists = r_out_data;

endmodule

@@ src/flwq_checker.sv @@
// Port-level checks for the fixed-length walk query block.
// Holds the checker module and the bind that attaches it to the top level.
// Depends on fixed_length_walk_query_top.
module flwq_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       i_mode,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_walk_exists
);

    // A result word held back by the sink stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_walk_exists)))
        else $error("result word changed while stalled");

    // Reset leaves no result word pending.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result word valid after reset");

    // An add-edge word never blocks the next word.
    a_add_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && !i_mode) |=> o_ready)
        else $error("input stalled after add-edge word");

    // A query word leaves the input side not ready once it is taken.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_mode) |=> !o_ready)
        else $error("input ready right after query word");

endmodule

bind fixed_length_walk_query_top flwq_checker u_flwq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .i_mode        (i_mode),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_walk_exists (o_walk_exists)
);
